[sv/read_end_mismatch_profiler_defines.svh]
// assertion macros for the read-end mismatch profiler
// no dependencies; included by the files that carry assertions
`ifndef READ_END_MISMATCH_PROFILER_DEFINES_SVH
`define READ_END_MISMATCH_PROFILER_DEFINES_SVH

// same-cycle implication, idle during reset
`define REMP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define REMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/remp_pkg.sv]
// shared constants, codes and control types of the read-end mismatch profiler
// no dependencies; imported by remp_ctrl, remp_datapath and the top level
package remp_pkg;

  // parameter defaults
  localparam int COUNT_BITS_DEF  = 32;
  localparam int LENGTH_BITS_DEF = 16;

  // fixed field widths
  localparam int END_BITS       = 10;
  localparam int MULT_BITS      = 8;
  localparam int BASE_BITS      = 48;
  localparam int FRAC_BITS      = 4;
  localparam int OP_BITS        = 2;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 10;

  // register reset values
  localparam logic [END_BITS-1:0]  END_LENGTH_RESET = 10'd10;
  localparam logic [MULT_BITS-1:0] ERROR_MULT_RESET = 8'd32;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_END_LENGTH = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ERROR_MULT = 1'd1;

  // input commands
  localparam logic CMD_RUN    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // operation kinds
  localparam logic [OP_BITS-1:0] OP_MATCH     = 2'd0;
  localparam logic [OP_BITS-1:0] OP_MISMATCH  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_INSERTION = 2'd2;
  localparam logic [OP_BITS-1:0] OP_DELETION  = 2'd3;

  // serial multiplier commands
  localparam int MS_BITS = 3;
  localparam logic [MS_BITS-1:0] MS_HOLD = 3'd0;
  localparam logic [MS_BITS-1:0] MS_STEP = 3'd1;
  localparam logic [MS_BITS-1:0] MS_LHS  = 3'd2;
  localparam logic [MS_BITS-1:0] MS_MD   = 3'd3;
  localparam logic [MS_BITS-1:0] MS_R    = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic               run_update;
    logic               span_load;
    logic [MS_BITS-1:0] mul_sel;
    logic               report_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic mul_done;
    logic skip;
  } stat_t;

endpackage

[sv/remp_datapath.sv]
// counters, run classifier, serial multiplier and result registers
// depends on remp_pkg; driven by remp_ctrl through ctrl_t
module remp_datapath #(
  parameter int COUNT_BITS  = remp_pkg::COUNT_BITS_DEF,
  parameter int LENGTH_BITS = remp_pkg::LENGTH_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [remp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [remp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [remp_pkg::OP_BITS-1:0]         op_kind,
  input  logic [LENGTH_BITS-1:0]               op_count,
  input  logic [LENGTH_BITS-1:0]               read_length,
  input  logic                                 last_op,
  input  remp_pkg::ctrl_t                      ctrl,
  output remp_pkg::stat_t                      stat,
  output logic                                 clean_needed,
  output logic                                 no_reads,
  output logic                                 degenerate,
  output logic [COUNT_BITS-1:0]                end_errors,
  output logic [COUNT_BITS-1:0]                middle_errors,
  output logic [COUNT_BITS-1:0]                reads_seen
);
  import remp_pkg::*;

  localparam int POS_BITS = LENGTH_BITS + 1;
  localparam int WIDE_LEN = (LENGTH_BITS > END_BITS) ? LENGTH_BITS : END_BITS;
  localparam int SW       = WIDE_LEN + 3;
  localparam int ADD_W    = ((COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS) + 1;
  localparam int TWOL_W   = END_BITS + 1;
  localparam int SPAN_W   = COUNT_BITS + TWOL_W;
  localparam int MR_W     = MULT_BITS + TWOL_W;
  localparam int CMP_W    = (SPAN_W > BASE_BITS) ? SPAN_W : BASE_BITS;
  localparam int PROD_W   = 2 * COUNT_BITS + BASE_BITS + FRAC_BITS;
  localparam int MPL_W    = (COUNT_BITS > BASE_BITS) ? COUNT_BITS : BASE_BITS;

  // configuration registers
  logic [END_BITS-1:0]  end_length;
  logic [MULT_BITS-1:0] error_mult;

  // accumulators
  logic [POS_BITS-1:0]   read_position;
  logic [COUNT_BITS-1:0] end_error_count;
  logic [COUNT_BITS-1:0] middle_error_count;
  logic [COUNT_BITS-1:0] read_count;
  logic [BASE_BITS-1:0]  base_total;

  // run classification
  logic signed [SW-1:0]  lo, hi, thr, lenl, lo_cl, hi_cl, diff;
  logic [LENGTH_BITS-1:0] mid, ends;
  logic [ADD_W-1:0]       mid_sum, end_sum;
  logic [COUNT_BITS-1:0]  mid_sat, end_sat, rc_inc;
  logic [POS_BITS:0]      pos_sum;
  logic [POS_BITS-1:0]    pos_sat, pos_next;
  logic [BASE_BITS:0]     base_sum;
  logic [BASE_BITS-1:0]   base_sat;

  // verdict
  logic [TWOL_W-1:0]    twol;
  logic [SPAN_W-1:0]    span_r;
  logic [MR_W-1:0]      mr_r;
  logic [BASE_BITS-1:0] s_val;
  logic                 reads_zero, base_le_span, degen_now;
  logic [PROD_W-1:0]    acc, mcand, lhs_r;
  logic [MPL_W-1:0]     mplier;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      end_length <= END_LENGTH_RESET;
      error_mult <= ERROR_MULT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_END_LENGTH: end_length <= cfg_data[END_BITS-1:0];
        REG_ERROR_MULT: error_mult <= cfg_data[MULT_BITS-1:0];
      endcase
    end
  end

  // middle region of this run: [max(pos+1, L), min(pos+cnt, len-L-1)]
  assign lo    = $signed(SW'(read_position)) + SW'(1);
  assign hi    = $signed(SW'(read_position)) + $signed(SW'(op_count));
  assign lenl  = $signed(SW'(end_length));
  assign thr   = $signed(SW'(read_length)) - lenl - SW'(1);
  assign lo_cl = (lo > lenl) ? lo : lenl;
  assign hi_cl = (hi < thr) ? hi : thr;
  assign diff  = hi_cl - lo_cl + SW'(1);
  assign mid   = (hi_cl >= lo_cl) ? diff[LENGTH_BITS-1:0] : '0;
  assign ends  = op_count - mid;

  // saturating counter sums
  assign mid_sum = ADD_W'(middle_error_count) + ADD_W'(mid);
  assign end_sum = ADD_W'(end_error_count) + ADD_W'(ends);
  assign mid_sat = (mid_sum > ADD_W'({COUNT_BITS{1'b1}})) ? '1 : mid_sum[COUNT_BITS-1:0];
  assign end_sat = (end_sum > ADD_W'({COUNT_BITS{1'b1}})) ? '1 : end_sum[COUNT_BITS-1:0];
  assign rc_inc  = (&read_count) ? read_count : read_count + 1'b1;

  // position and base total
  assign pos_sum  = (POS_BITS + 1)'(read_position) + (POS_BITS + 1)'(op_count);
  assign pos_sat  = pos_sum[POS_BITS] ? '1 : pos_sum[POS_BITS-1:0];
  assign base_sum = (BASE_BITS + 1)'(base_total) + (BASE_BITS + 1)'(read_length);
  assign base_sat = base_sum[BASE_BITS] ? '1 : base_sum[BASE_BITS-1:0];

  always_comb begin
    pos_next = (op_kind != OP_DELETION) ? pos_sat : read_position;
    if (last_op) pos_next = '0;
  end

  // accumulator update, cleared by each report
  always_ff @(posedge clk) begin
    if (rst || ctrl.report_load) begin
      read_position      <= '0;
      end_error_count    <= '0;
      middle_error_count <= '0;
      read_count         <= '0;
      base_total         <= '0;
    end else if (ctrl.run_update) begin
      read_position <= pos_next;
      if (op_kind == OP_MISMATCH) begin
        middle_error_count <= mid_sat;
        end_error_count    <= end_sat;
      end
      if (last_op) begin
        read_count <= rc_inc;
        base_total <= base_sat;
      end
    end
  end

  // span 2*L*R and threshold product M*2*L
  assign twol = {end_length, 1'b0};

  always_ff @(posedge clk) begin
    if (ctrl.span_load) begin
      span_r <= SPAN_W'(twol) * SPAN_W'(read_count);
      mr_r   <= MR_W'(twol) * MR_W'(error_mult);
    end
  end

  // special cases
  assign reads_zero   = (read_count == '0);
  assign base_le_span = (CMP_W'(base_total) <= CMP_W'(span_r));
  assign degen_now    = (end_length == '0) || base_le_span;
  assign s_val        = base_total - BASE_BITS'(span_r);

  assign stat.skip     = reads_zero || degen_now;
  assign stat.mul_done = (mplier == '0);

  // shift-and-add multiplier, one multiplier bit a cycle while the controller steps it
  always_ff @(posedge clk) begin
    unique case (ctrl.mul_sel)
      MS_STEP: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
      end
      MS_LHS: begin
        acc    <= '0;
        mcand  <= PROD_W'({end_error_count, {FRAC_BITS{1'b0}}});
        mplier <= MPL_W'(s_val);
      end
      MS_MD: begin
        lhs_r  <= acc;
        acc    <= '0;
        mcand  <= PROD_W'(mr_r);
        mplier <= MPL_W'(middle_error_count);
      end
      MS_R: begin
        acc    <= '0;
        mcand  <= acc;
        mplier <= MPL_W'(read_count);
      end
      default: ;
    endcase
  end

  // result word
  always_ff @(posedge clk) begin
    if (ctrl.report_load) begin
      no_reads      <= reads_zero;
      degenerate    <= !reads_zero && degen_now;
      clean_needed  <= !reads_zero && !degen_now && (lhs_r > acc);
      end_errors    <= end_error_count;
      middle_errors <= middle_error_count;
      reads_seen    <= read_count;
    end
  end

endmodule

[sv/remp_ctrl.sv]
// sequencer for the read-end mismatch profiler: handshakes and finish steps
// depends on remp_pkg and read_end_mismatch_profiler_defines.svh
`include "read_end_mismatch_profiler_defines.svh"

module remp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output remp_pkg::ctrl_t ctrl,
  input  remp_pkg::stat_t stat
);
  import remp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SPAN   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_MUL_L  = 3'd3;
  localparam logic [2:0] S_MUL_D  = 3'd4;
  localparam logic [2:0] S_MUL_R  = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       accept;

  // no word is taken while reset is held
  assign in_ready = !rst && (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and datapath commands
  always_comb begin
    state_next       = state;
    ctrl.run_update  = 1'b0;
    ctrl.span_load   = 1'b0;
    ctrl.mul_sel     = MS_HOLD;
    ctrl.report_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_FINISH) state_next = S_SPAN;
          else ctrl.run_update = 1'b1;
        end
      end
      S_SPAN: begin
        ctrl.span_load = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (stat.skip) begin
          state_next = S_REPORT;
        end else begin
          ctrl.mul_sel = MS_LHS;
          state_next   = S_MUL_L;
        end
      end
      S_MUL_L: begin
        if (stat.mul_done) begin
          ctrl.mul_sel = MS_MD;
          state_next   = S_MUL_D;
        end else begin
          ctrl.mul_sel = MS_STEP;
        end
      end
      S_MUL_D: begin
        if (stat.mul_done) begin
          ctrl.mul_sel = MS_R;
          state_next   = S_MUL_R;
        end else begin
          ctrl.mul_sel = MS_STEP;
        end
      end
      S_MUL_R: begin
        if (stat.mul_done) state_next = S_REPORT;
        else ctrl.mul_sel = MS_STEP;
      end
      S_REPORT: begin
        if (!out_valid || out_ready) begin
          ctrl.report_load = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output word valid
  always_comb begin
    if (ctrl.report_load) out_valid_next = 1'b1;
    else if (out_ready)   out_valid_next = 1'b0;
    else                  out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `REMP_ASSERT_IMPLY(a_no_overwrite, clk, rst, ctrl.report_load, !out_valid || out_ready, "result word overwritten")
  `REMP_ASSERT_NEXT(a_finish_starts, clk, rst, accept && cmd == CMD_FINISH, state == S_SPAN, "finish did not start")
  `REMP_ASSERT_IMPLY(a_step_in_mul, clk, rst, ctrl.mul_sel == MS_STEP, state == S_MUL_L || state == S_MUL_D || state == S_MUL_R, "multiplier step outside multiply")
  `REMP_ASSERT_NEXT(a_report_shows, clk, rst, ctrl.report_load, out_valid && state == S_IDLE, "report not presented")
  `REMP_ASSERT_IMPLY(a_run_idle, clk, rst, ctrl.run_update, state == S_IDLE && cmd == CMD_RUN, "run update outside idle")

endmodule

[sv/read_end_mismatch_profiler.sv]
// channel   | handshake             | word
// ----------+-----------------------+-------------------------------------------------
// input     | in_valid / in_ready   | cmd, op_kind, op_count, read_length, last_op
// output    | out_valid / out_ready | clean_needed, no_reads, degenerate, counts
// config    | cfg_valid / cfg_ready | cfg_index, cfg_data (ready whenever out of reset)
//
// run words: one per cycle while no finish is under way, counters updated at the accept edge
// finish word: span and check steps, then the report step when there are no reads or the
//   span is degenerate, else the multiplies for S, D and R first, by the one-bit-a-cycle
//   shift-add multiplier; input is held off during that time
// the output register holds a finished word while new runs are taken;
//   a second finish waits in the report step until that word is taken
// synchronous active-high reset: registers back to 10 and 32, counters to zero
// top level; depends on remp_pkg, remp_ctrl, remp_datapath
module read_end_mismatch_profiler #(
  parameter int COUNT_BITS  = remp_pkg::COUNT_BITS_DEF,
  parameter int LENGTH_BITS = remp_pkg::LENGTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [remp_pkg::OP_BITS-1:0]        op_kind,
  input  logic [LENGTH_BITS-1:0]              op_count,
  input  logic [LENGTH_BITS-1:0]              read_length,
  input  logic                                last_op,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                clean_needed,
  output logic                                no_reads,
  output logic                                degenerate,
  output logic [COUNT_BITS-1:0]               end_errors,
  output logic [COUNT_BITS-1:0]               middle_errors,
  output logic [COUNT_BITS-1:0]               reads_seen,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [remp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [remp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import remp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // registers take a write in any cycle out of reset
  assign cfg_ready = !rst;

  remp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  remp_datapath #(
    .COUNT_BITS  (COUNT_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .op_kind       (op_kind),
    .op_count      (op_count),
    .read_length   (read_length),
    .last_op       (last_op),
    .ctrl          (ctrl),
    .stat          (stat),
    .clean_needed  (clean_needed),
    .no_reads      (no_reads),
    .degenerate    (degenerate),
    .end_errors    (end_errors),
    .middle_errors (middle_errors),
    .reads_seen    (reads_seen)
  );

endmodule

[bench/read_end_mismatch_profiler_test.sv]
`timescale 1ns / 100ps
// testbench for read_end_mismatch_profiler: directed and random run/finish words,
// with predicted reports checked in order; depends on remp_pkg and the block's rtl
module read_end_mismatch_profiler_test;
  import remp_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int LEN_W = LENGTH_BITS_DEF;
  localparam longint unsigned CNT_MAX = (64'd1 << CNT_W) - 1;
  localparam longint unsigned POS_MAX = (64'd1 << (LEN_W + 1)) - 1;
  localparam longint unsigned BASE_MAX = (64'd1 << BASE_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 7 + BASE_BITS + 2 * CNT_W + 20;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic             clean_needed;
    logic             no_reads;
    logic             degenerate;
    logic [CNT_W-1:0] end_errors;
    logic [CNT_W-1:0] middle_errors;
    logic [CNT_W-1:0] reads_seen;
  } report_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      cmd = 1'b0;
  logic [OP_BITS-1:0]        op_kind = '0;
  logic [LEN_W-1:0]          op_count = '0;
  logic [LEN_W-1:0]          read_length = '0;
  logic                      last_op = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      clean_needed;
  logic                      no_reads;
  logic                      degenerate;
  logic [CNT_W-1:0]          end_errors;
  logic [CNT_W-1:0]          middle_errors;
  logic [CNT_W-1:0]          reads_seen;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // profiler state as predicted by the bench
  logic [END_BITS-1:0]  end_len_q = END_LENGTH_RESET;
  logic [MULT_BITS-1:0] mult_q = ERROR_MULT_RESET;
  longint unsigned      pos_q = 0;
  longint unsigned      end_hits = 0;
  longint unsigned      mid_hits = 0;
  longint unsigned      reads_q = 0;
  longint unsigned      bases_q = 0;
  report_t              pending_reports[$];

  logic        idle_on = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;
  int unsigned reports_checked = 0;
  int unsigned settings_used = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  read_end_mismatch_profiler #(
    .COUNT_BITS(CNT_W),
    .LENGTH_BITS(LEN_W)
  ) dut (.*);

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                              longint unsigned lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  // advance the predicted state by one accepted word, queue a report on finish
  task automatic profile_word(input logic c, input logic [OP_BITS-1:0] k,
                              input logic [LEN_W-1:0] n, input logic [LEN_W-1:0] len,
                              input logic last);
    longint lo, hi, lim_hi, a, b, l_end, mid;
    longint unsigned twol, span;
    logic [127:0] lhs, rhs;
    report_t r;
    if (c == CMD_RUN) begin
      // split the mismatched positions lo..hi between read ends and middle
      if (k == OP_MISMATCH && n != 0) begin
        l_end = end_len_q;
        lo = pos_q + 1;
        hi = pos_q + n;
        lim_hi = len;
        lim_hi = lim_hi - l_end - 1;
        a = (lo > l_end) ? lo : l_end;
        b = (hi < lim_hi) ? hi : lim_hi;
        mid = (b >= a) ? b - a + 1 : 0;
        mid_hits = sat_sum(mid_hits, mid, CNT_MAX);
        end_hits = sat_sum(end_hits, n - mid, CNT_MAX);
      end
      if (k != OP_DELETION) pos_q = sat_sum(pos_q, n, POS_MAX);
      if (last) begin
        reads_q = sat_sum(reads_q, 1, CNT_MAX);
        bases_q = sat_sum(bases_q, len, BASE_MAX);
        pos_q = 0;
      end
    end else begin
      r = '0;
      r.end_errors = CNT_W'(end_hits);
      r.middle_errors = CNT_W'(mid_hits);
      r.reads_seen = CNT_W'(reads_q);
      if (reads_q == 0) begin
        r.no_reads = 1'b1;
      end else begin
        twol = 2 * end_len_q;
        span = twol * reads_q;
        if (end_len_q == 0 || bases_q <= span) begin
          r.degenerate = 1'b1;
        end else begin
          // cross-multiplied rate compare, exact at 128 bits
          lhs = 128'(end_hits);
          lhs = lhs * 16 * (bases_q - span);
          rhs = 128'(mult_q);
          rhs = rhs * twol * mid_hits * reads_q;
          r.clean_needed = (lhs > rhs);
        end
      end
      pending_reports.push_back(r);
      pos_q = 0;
      end_hits = 0;
      mid_hits = 0;
      reads_q = 0;
      bases_q = 0;
    end
  endtask

  // offer one word, at times with in_valid dropped ahead of it
  task automatic send_word(input logic c, input logic [OP_BITS-1:0] k,
                           input logic [LEN_W-1:0] n, input logic [LEN_W-1:0] len,
                           input logic last);
    if (idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    op_kind <= k;
    op_count <= n;
    read_length <= len;
    last_op <= last;
    do @(posedge clk); while (!in_ready);
    profile_word(c, k, n, len, last);
    words_sent++;
  endtask

  // drop the input and let every pending report drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic program_profile(input logic [CFG_DATA_BITS-1:0] l_data,
                                 input logic [CFG_DATA_BITS-1:0] m_data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_END_LENGTH;
    cfg_data <= l_data;
    do @(posedge clk); while (!cfg_ready);
    end_len_q = l_data;
    cfg_index <= REG_ERROR_MULT;
    cfg_data <= m_data;
    do @(posedge clk); while (!cfg_ready);
    mult_q = m_data[MULT_BITS-1:0];
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // one well-formed read: runs that consume exactly read_length bases
  task automatic send_read();
    int unsigned len, left, cnt, runs, head, tail, roll;
    logic [OP_BITS-1:0] kind;
    roll = $urandom_range(99);
    if (roll < 65) len = $urandom_range(200, 1);
    else if (roll < 80) len = $urandom_range(4000, 201);
    else if (roll < 88) len = 0;
    else if (roll < 94) len = 65535;
    else len = $urandom_range(65535);
    left = len;
    if ($urandom_range(3) == 0) begin
      // mismatches bunched at both ends, matches in between
      head = $urandom_range(12, 1);
      if (head > left) head = left;
      tail = $urandom_range(12, 1);
      if (tail > left - head) tail = left - head;
      send_word(CMD_RUN, OP_MISMATCH, LEN_W'(head), LEN_W'(len), 1'b0);
      send_word(CMD_RUN, OP_MATCH, LEN_W'(left - head - tail), LEN_W'(len), 1'b0);
      send_word(CMD_RUN, OP_MISMATCH, LEN_W'(tail), LEN_W'(len), 1'b1);
    end else begin
      runs = $urandom_range(8, 1);
      repeat (runs - 1) begin
        kind = OP_BITS'($urandom_range(OP_DELETION));
        cnt = (left == 0) ? 0 : $urandom_range(left > 60 ? 60 : left, 1);
        if (kind != OP_DELETION) left -= cnt;
        send_word(CMD_RUN, kind, LEN_W'(cnt), LEN_W'(len), 1'b0);
      end
      kind = OP_BITS'($urandom_range(OP_INSERTION));
      send_word(CMD_RUN, kind, LEN_W'(left), LEN_W'(len), 1'b1);
    end
  endtask

  task automatic test_finish_without_reads();
    send_word(CMD_FINISH, OP_DELETION, '1, '1, 1'b1);
    // errors counted but no read closed
    send_word(CMD_RUN, OP_MISMATCH, 5, 20, 1'b0);
    send_word(CMD_FINISH, OP_MATCH, 0, 0, 1'b0);
  endtask

  task automatic test_operation_kinds();
    send_word(CMD_RUN, OP_MATCH, 10, 40, 1'b0);
    send_word(CMD_RUN, OP_MISMATCH, 8, 40, 1'b0);
    send_word(CMD_RUN, OP_MISMATCH, 0, 40, 1'b0);
    send_word(CMD_RUN, OP_INSERTION, 3, 40, 1'b0);
    send_word(CMD_RUN, OP_DELETION, 4, 40, 1'b0);
    send_word(CMD_RUN, OP_MISMATCH, 19, 40, 1'b1);
    send_word(CMD_FINISH, OP_MATCH, 0, 0, 1'b0);
  endtask

  task automatic test_field_extremes();
    // empty read and full-length read, both all mismatches
    send_word(CMD_RUN, OP_MISMATCH, '1, 0, 1'b1);
    send_word(CMD_RUN, OP_MISMATCH, '1, '1, 1'b1);
    send_word(CMD_FINISH, OP_DELETION, '1, '1, 1'b1);
    // position runs past its maximum, then a deletion closes a read
    send_word(CMD_RUN, OP_MATCH, '1, '1, 1'b0);
    send_word(CMD_RUN, OP_MATCH, '1, '1, 1'b0);
    send_word(CMD_RUN, OP_MISMATCH, '1, '1, 1'b0);
    send_word(CMD_RUN, OP_MISMATCH, 3, '1, 1'b1);
    send_word(CMD_RUN, OP_DELETION, '1, 100, 1'b1);
    send_word(CMD_FINISH, OP_MISMATCH, 0, 0, 1'b0);
  endtask

  task automatic test_degenerate_spans();
    // zero end length
    program_profile(0, 32);
    send_word(CMD_RUN, OP_MISMATCH, 5, 30, 1'b1);
    send_word(CMD_FINISH, OP_MATCH, 0, 0, 1'b0);
    // middle span negative, then exactly zero
    program_profile(10, 32);
    send_word(CMD_RUN, OP_MATCH, 15, 15, 1'b1);
    send_word(CMD_FINISH, OP_MATCH, 0, 0, 1'b0);
    send_word(CMD_RUN, OP_MISMATCH, 20, 20, 1'b1);
    send_word(CMD_FINISH, OP_MATCH, 0, 0, 1'b0);
  endtask

  task automatic test_random_reads(input int unsigned words,
                                   input logic [CFG_DATA_BITS-1:0] l_data,
                                   input logic [CFG_DATA_BITS-1:0] m_data);
    int unsigned stop_at, roll;
    program_profile(l_data, m_data);
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 10)
        send_word(CMD_RUN, OP_BITS'($urandom_range(OP_DELETION)), LEN_W'($urandom),
                  LEN_W'($urandom), 1'($urandom_range(1)));
      else if (roll < 28)
        send_word(CMD_FINISH, OP_BITS'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                  1'($urandom));
      else
        send_read();
    end
  endtask

  // receiver stalls long enough for a second finish to back up the input
  task automatic test_backpressure();
    program_profile(10, 32);
    hold_req = HOLD_CYCLES;
    repeat (3) begin
      send_read();
      send_word(CMD_FINISH, OP_MATCH, 0, 0, 1'b0);
    end
  endtask

  // long back-to-back stretch of full mismatch runs, no idling on either side
  task automatic test_dense_mismatches();
    program_profile(1, 255);
    idle_on = 1'b0;
    repeat (20) begin
      send_word(CMD_RUN, OP_MISMATCH, '1, '1, 1'b0);
      send_word(CMD_RUN, OP_MISMATCH, '1, '1, 1'b1);
    end
    send_word(CMD_FINISH, OP_MATCH, 0, 0, 1'b0);
    idle_on = 1'b1;
  endtask

  // receiver: random ready, long hold when asked
  always @(posedge clk) begin
    if (hold_left == 0 && hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 9);
    end
  end

  // compare each report word with the oldest prediction
  always @(posedge clk) begin
    report_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {clean_needed, no_reads, degenerate, end_errors, middle_errors, reads_seen};
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected report word: clean=%0d none=%0d degen=%0d end=%0d mid=%0d reads=%0d",
                   got.clean_needed, got.no_reads, got.degenerate, got.end_errors,
                   got.middle_errors, got.reads_seen);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("report %0d mismatch", reports_checked);
            $display("  expected clean=%0d none=%0d degen=%0d end=%0d mid=%0d reads=%0d",
                     want.clean_needed, want.no_reads, want.degenerate, want.end_errors,
                     want.middle_errors, want.reads_seen);
            $display("  actual   clean=%0d none=%0d degen=%0d end=%0d mid=%0d reads=%0d",
                     got.clean_needed, got.no_reads, got.degenerate, got.end_errors,
                     got.middle_errors, got.reads_seen);
          end
        end
      end
      reports_checked++;
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_finish_without_reads();
    test_operation_kinds();
    test_field_extremes();
    test_degenerate_spans();
    test_random_reads(110, 10, 32);
    test_random_reads(110, 20, 16);
    test_random_reads(110, 1023, 255);
    idle_on = 1'b0;
    test_random_reads(110, 3, 0);
    idle_on = 1'b1;
    test_random_reads(110, CFG_DATA_BITS'($urandom_range(40, 1)), 10'h3FF);
    test_random_reads(110, CFG_DATA_BITS'($urandom_range(1023)),
                      CFG_DATA_BITS'($urandom_range(255)));
    test_backpressure();
    test_dense_mismatches();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input words and %0d report words over %0d register settings",
             words_sent, reports_checked, settings_used);
    $display("including empty and degenerate finishes, position overflow, output stall");
    $display("and a long back-to-back stretch with no idling");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[read_end_mismatch_profiler.f]
+incdir+sv
sv/remp_pkg.sv
sv/remp_datapath.sv
sv/remp_ctrl.sv
sv/read_end_mismatch_profiler.sv
bench/read_end_mismatch_profiler_test.sv
